FILE: src/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg: shared types and constants for the dense shortest-path engine
// Field widths, request codes and default sizing used by the interfaces,
// the arithmetic unit and the top level.
// ----------------------------------------------------------------------------
package dds_pkg;

    // Default sizing of the node set and of a stored edge weight
    localparam int MAX_NODES_DEF   = 16;
    localparam int WEIGHT_BITS_DEF = 12;

    // Fixed field widths of the channels
    localparam int NODE_FIELD_W   = 4;
    localparam int WEIGHT_FIELD_W = 12;
    localparam int COUNT_W        = 5;
    localparam int DIST_W         = 16;

    // Distance saturation point, node count after reset and minimum node count
    localparam logic [DIST_W-1:0]  DIST_MAX         = 16'hFFFF;
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 5'd10;
    localparam logic [COUNT_W-1:0] NODE_COUNT_MIN   = 5'd2;

    // Request codes
    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } op_t;

endpackage

FILE: src/dds_if.sv
// ----------------------------------------------------------------------------
// dds_if: valid/ready channels of the shortest-path engine
// Request channel, result channel and node-count write channel.
// ----------------------------------------------------------------------------
interface dds_req_if;
    logic                                   valid;
    logic                                   ready;
    dds_pkg::op_t                           operation;
    logic [dds_pkg::NODE_FIELD_W-1:0]       from_node;
    logic [dds_pkg::NODE_FIELD_W-1:0]       to_node;
    logic [dds_pkg::WEIGHT_FIELD_W-1:0]     edge_weight;
    logic [dds_pkg::NODE_FIELD_W-1:0]       source_node;

    modport source
    (
        output valid, operation, from_node, to_node, edge_weight, source_node,
        input  ready
    );
    modport sink
    (
        input  valid, operation, from_node, to_node, edge_weight, source_node,
        output ready
    );
endinterface

interface dds_res_if;
    logic                               valid;
    logic                               ready;
    logic [dds_pkg::NODE_FIELD_W-1:0]   node_index;
    logic [dds_pkg::DIST_W-1:0]         path_distance;
    logic [dds_pkg::NODE_FIELD_W-1:0]   predecessor;
    logic                               reachable;
    logic                               last_result;

    modport source
    (
        output valid, node_index, path_distance, predecessor, reachable, last_result,
        input  ready
    );
    modport sink
    (
        input  valid, node_index, path_distance, predecessor, reachable, last_result,
        output ready
    );
endinterface

interface dds_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dds_pkg::COUNT_W-1:0]    node_count;

    modport source
    (
        output valid, node_count,
        input  ready
    );
    modport sink
    (
        input  valid, node_count,
        output ready
    );
endinterface

FILE: src/dds_ram.sv
// ----------------------------------------------------------------------------
// dds_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/dds_unit.sv
// ----------------------------------------------------------------------------
// dds_unit: shared saturating add and compare unit
// Select pass: flags a stored distance below the running minimum.
// Relax pass: forms base plus edge weight, saturated, and flags it below
// the stored distance.
// ----------------------------------------------------------------------------
module dds_unit #(
    parameter int WEIGHT_BITS = dds_pkg::WEIGHT_BITS_DEF
) (
    input  logic                       relax_mode,
    input  logic [dds_pkg::DIST_W-1:0] base,
    input  logic [WEIGHT_BITS-1:0]     weight,
    input  logic [dds_pkg::DIST_W-1:0] stored,
    output logic [dds_pkg::DIST_W-1:0] sum,
    output logic                       less
);

    localparam int SUM_W = ((WEIGHT_BITS > dds_pkg::DIST_W) ? WEIGHT_BITS : dds_pkg::DIST_W) + 1;

    logic [SUM_W-1:0]           raw_sum;
    logic [dds_pkg::DIST_W-1:0] cmp_a;
    logic [dds_pkg::DIST_W-1:0] cmp_b;

    // Add and clamp to the distance range
    always_comb
    begin
        raw_sum = SUM_W'(base) + SUM_W'(weight);
        if (raw_sum > SUM_W'(dds_pkg::DIST_MAX))
        begin
            sum = dds_pkg::DIST_MAX;
        end
        else
        begin
            sum = raw_sum[dds_pkg::DIST_W-1:0];
        end
    end

    // Steer the comparator by pass
    always_comb
    begin
        cmp_a = relax_mode ? sum    : stored;
        cmp_b = relax_mode ? stored : base;
        less  = cmp_a < cmp_b;
    end

endmodule

FILE: src/dense_dijkstra_shortest_paths.sv
// ----------------------------------------------------------------------------
// dense_dijkstra_shortest_paths: single-source shortest paths, dense matrix
// Loads edge weights into a matrix RAM, then on a run request settles nodes
// nearest first and streams distance and predecessor for each other node.
//
//  Channel  Dir  Handshake      Carries
//  req      in   valid/ready    operation, from_node, to_node, edge_weight,
//                               source_node
//  res      out  valid/ready    node_index, path_distance, predecessor,
//                               reachable, last_result
//  cfg      in   valid/ready    node_count (always ready)
//
//  A load request writes the weight RAM as it is taken. A run has a setup
//  step, then for each settled node a select scan and a relax scan, one more
//  select scan unless every node settled, a step to skip the source unless it
//  is node n-1, and a read, a load and a wait on res for each result.
//  Both scans pass through one node RAM read port and one weight RAM read
//  port, one entry a cycle; all compares and adds share one unit.
//  req is not ready from the start of a run until its last result is taken.
//  Reset needs no clearing pass; the RAMs hold no reset state.
// ----------------------------------------------------------------------------
module dense_dijkstra_shortest_paths #(
    parameter int MAX_NODES   = dds_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = dds_pkg::WEIGHT_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    dds_req_if.sink   req,
    dds_res_if.source res,
    dds_cfg_if.sink   cfg
);

    localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int WADDR_W = $clog2(MAX_NODES * MAX_NODES);
    localparam int NRAM_W  = dds_pkg::DIST_W + NODE_W;

    typedef enum logic [6:0]
    {
        ST_IDLE     = 7'b0000001,
        ST_INIT     = 7'b0000010,
        ST_SEL      = 7'b0000100,
        ST_RELAX    = 7'b0001000,
        ST_OUT_RD   = 7'b0010000,
        ST_OUT_LD   = 7'b0100000,
        ST_OUT_WAIT = 7'b1000000
    } state_t;

    state_t                       state_reg,   state_next;
    logic [CNT_W-1:0]             idx_reg,     idx_next;
    logic [NODE_W-1:0]            idx_d_reg,   idx_d_next;
    logic                         stg_vld_reg, stg_vld_next;
    logic                         found_reg,   found_next;
    logic [CNT_W-1:0]             settled_reg, settled_next;
    logic [MAX_NODES-1:0]         reach_reg,   reach_next;
    logic [MAX_NODES-1:0]         visited_reg, visited_next;
    logic                         res_vld_reg, res_vld_next;
    logic [dds_pkg::COUNT_W-1:0]  node_cnt_reg;
    logic [NODE_W-1:0]            pick_reg,    pick_next;
    logic [dds_pkg::DIST_W-1:0]   min_reg,     min_next;
    logic [NODE_W-1:0]            src_reg,     src_next;

    logic [dds_pkg::NODE_FIELD_W-1:0] node_index_reg;
    logic [dds_pkg::DIST_W-1:0]       distance_reg;
    logic [dds_pkg::NODE_FIELD_W-1:0] predecessor_reg;
    logic                             reachable_reg;
    logic                             last_reg;

    logic [CNT_W-1:0]           n_use;
    logic [CNT_W-1:0]           n_m1;
    logic [CNT_W-1:0]           n_m2;
    logic [NODE_W-1:0]          idx_low;
    logic                       req_fire;
    logic                       load_ok;
    logic                       scan_done;
    logic                       is_last;
    logic                       load_out;

    logic                       w_we;
    logic [WADDR_W-1:0]         w_waddr;
    logic [WADDR_W-1:0]         w_raddr;
    logic [WEIGHT_BITS-1:0]     w_rdata;

    logic                       n_we;
    logic [NODE_W-1:0]          n_waddr;
    logic [NRAM_W-1:0]          n_wdata;
    logic [NRAM_W-1:0]          n_rdata;
    logic [dds_pkg::DIST_W-1:0] rd_dist;
    logic [NODE_W-1:0]          rd_prev;

    logic                       relax_mode;
    logic [dds_pkg::DIST_W-1:0] cand;
    logic                       less;
    logic                       sel_take;
    logic                       relax_take;

    // Clamp the node count to the supported range
    always_comb
    begin
        if (node_cnt_reg < dds_pkg::NODE_COUNT_MIN)
        begin
            n_use = CNT_W'(2);
        end
        else if (int'(node_cnt_reg) > MAX_NODES)
        begin
            n_use = CNT_W'(MAX_NODES);
        end
        else
        begin
            n_use = CNT_W'(node_cnt_reg);
        end
        n_m1 = n_use - CNT_W'(1);
        n_m2 = n_use - CNT_W'(2);
    end

    // Handshakes
    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign req_fire  = req.valid && req.ready;
    assign idx_low   = idx_reg[NODE_W-1:0];

    assign res.valid         = res_vld_reg;
    assign res.node_index    = node_index_reg;
    assign res.path_distance = distance_reg;
    assign res.predecessor   = predecessor_reg;
    assign res.reachable     = reachable_reg;
    assign res.last_result   = last_reg;

    // Weight matrix: write on load, read row of the picked node on relax
    assign load_ok = req_fire && (req.operation == dds_pkg::OP_LOAD)
                     && (int'(req.from_node) < MAX_NODES)
                     && (int'(req.to_node) < MAX_NODES);
    assign w_we    = load_ok;
    assign w_waddr = WADDR_W'(WADDR_W'(req.from_node) * WADDR_W'(MAX_NODES)
                              + WADDR_W'(req.to_node));
    assign w_raddr = WADDR_W'(WADDR_W'(pick_reg) * WADDR_W'(MAX_NODES)
                              + WADDR_W'(idx_low));

    dds_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_NODES * MAX_NODES)
    ) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (WEIGHT_BITS'(req.edge_weight)),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    // Node table: distance and predecessor, valid where reach bit is set
    dds_ram #(
        .WIDTH (NRAM_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (idx_low),
        .rdata (n_rdata)
    );

    assign rd_dist = n_rdata[NRAM_W-1:NODE_W];
    assign rd_prev = n_rdata[NODE_W-1:0];

    // Shared add and compare
    assign relax_mode = (state_reg == ST_RELAX);

    dds_unit #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_unit (
        .relax_mode (relax_mode),
        .base       (min_reg),
        .weight     (w_rdata),
        .stored     (rd_dist),
        .sum        (cand),
        .less       (less)
    );

    // Evaluate the entry returned by the RAMs
    assign sel_take   = stg_vld_reg && !visited_reg[idx_d_reg] && reach_reg[idx_d_reg]
                        && (!found_reg || less);
    assign relax_take = stg_vld_reg && !visited_reg[idx_d_reg] && (w_rdata != '0)
                        && (!reach_reg[idx_d_reg] || less);
    assign scan_done  = (idx_reg == n_use) && !stg_vld_reg;
    assign is_last    = (idx_reg == n_m1)
                        || ((idx_reg == n_m2) && (CNT_W'(src_reg) == n_m1));

    // Node table write: seed the source, then improved distances
    always_comb
    begin
        n_we    = 1'b0;
        n_waddr = idx_d_reg;
        n_wdata = {cand, pick_reg};
        if (state_reg == ST_INIT)
        begin
            n_we    = 1'b1;
            n_waddr = src_reg;
            n_wdata = {dds_pkg::DIST_W'(0), src_reg};
        end
        else if (state_reg == ST_RELAX)
        begin
            n_we = relax_take;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        idx_d_next   = idx_low;
        stg_vld_next = 1'b0;
        found_next   = found_reg;
        settled_next = settled_reg;
        reach_next   = reach_reg;
        visited_next = visited_reg;
        res_vld_next = res_vld_reg;
        pick_next    = pick_reg;
        min_next     = min_reg;
        src_next     = src_reg;
        load_out     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.operation == dds_pkg::OP_RUN)
                    && (int'(req.source_node) < int'(n_use)))
                begin
                    src_next   = NODE_W'(req.source_node);
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                reach_next          = '0;
                reach_next[src_reg] = 1'b1;
                visited_next        = '0;
                settled_next        = '0;
                idx_next            = '0;
                found_next          = 1'b0;
                state_next          = ST_SEL;
            end
            ST_SEL:
            begin
                if (idx_reg != n_use)
                begin
                    idx_next     = CNT_W'(idx_reg + 1'b1);
                    stg_vld_next = 1'b1;
                end
                if (sel_take)
                begin
                    found_next = 1'b1;
                    pick_next  = idx_d_reg;
                    min_next   = rd_dist;
                end
                if (scan_done)
                begin
                    idx_next = '0;
                    if (found_reg)
                    begin
                        visited_next[pick_reg] = 1'b1;
                        settled_next           = CNT_W'(settled_reg + 1'b1);
                        state_next             = ST_RELAX;
                    end
                    else
                    begin
                        state_next = ST_OUT_RD;
                    end
                end
            end
            ST_RELAX:
            begin
                if (idx_reg != n_use)
                begin
                    idx_next     = CNT_W'(idx_reg + 1'b1);
                    stg_vld_next = 1'b1;
                end
                if (relax_take)
                begin
                    reach_next[idx_d_reg] = 1'b1;
                end
                if (scan_done)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = (settled_reg == n_use) ? ST_OUT_RD : ST_SEL;
                end
            end
            ST_OUT_RD:
            begin
                if (idx_reg == n_use)
                begin
                    state_next = ST_IDLE;
                end
                else if (idx_reg == CNT_W'(src_reg))
                begin
                    idx_next = CNT_W'(idx_reg + 1'b1);
                end
                else
                begin
                    state_next = ST_OUT_LD;
                end
            end
            ST_OUT_LD:
            begin
                load_out     = 1'b1;
                res_vld_next = 1'b1;
                state_next   = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (res.ready)
                begin
                    res_vld_next = 1'b0;
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = CNT_W'(idx_reg + 1'b1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            idx_d_reg    <= '0;
            stg_vld_reg  <= 1'b0;
            found_reg    <= 1'b0;
            settled_reg  <= '0;
            reach_reg    <= '0;
            visited_reg  <= '0;
            res_vld_reg  <= 1'b0;
            node_cnt_reg <= dds_pkg::NODE_COUNT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            idx_d_reg   <= idx_d_next;
            stg_vld_reg <= stg_vld_next;
            found_reg   <= found_next;
            settled_reg <= settled_next;
            reach_reg   <= reach_next;
            visited_reg <= visited_next;
            res_vld_reg <= res_vld_next;
            if (cfg.valid && cfg.ready)
            begin
                node_cnt_reg <= cfg.node_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
        min_reg  <= min_next;
        src_reg  <= src_next;
        if (load_out)
        begin
            node_index_reg  <= dds_pkg::NODE_FIELD_W'(idx_low);
            distance_reg    <= reach_reg[idx_low] ? rd_dist : '0;
            predecessor_reg <= dds_pkg::NODE_FIELD_W'(reach_reg[idx_low] ? rd_prev : src_reg);
            reachable_reg   <= reach_reg[idx_low];
            last_reg        <= is_last;
        end
    end

    // Checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !req.ready)
        else $error("result pending while request channel is ready");

    a_pick_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEL) && scan_done && found_reg |-> !visited_reg[pick_reg])
        else $error("select picked an already settled node");

    a_relax_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RELAX) && n_we |-> !visited_reg[n_waddr])
        else $error("relax wrote a settled node");

    a_settled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEL) || (state_reg == ST_RELAX) |-> settled_reg <= n_use)
        else $error("settled count beyond node count");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.ready && res.last_result |=> (state_reg == ST_IDLE))
        else $error("run continued after final result");

endmodule
